>>> hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and codes for the buddy page allocator: request and result
// transactions, the classified command between front and back, back states.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// page space holds 2^PAGE_INDEX_BITS pages, matching the transaction fields
	localparam int PAGE_INDEX_BITS = 12;

	// request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_ZERO     = 3'd1;
	localparam logic [2:0] STAT_EXCEEDS  = 3'd2;
	localparam logic [2:0] STAT_NO_BLOCK = 3'd3;
	localparam logic [2:0] STAT_PAST_END = 3'd4;

	// rounded order of a 13-bit count fits in this many bits
	localparam int ORD_W = 4;

	typedef struct packed {
		logic        opcode;
		logic [12:0] page_count;
		logic [11:0] first_page;
	} bpa_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] granted_page;
		logic [12:0] pages_free;
	} bpa_rsp_t;

	typedef enum logic [1:0] {
		CMD_REJECT,
		CMD_FREE,
		CMD_ALLOC
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [2:0]       rej_status;
		logic             big;
		logic [12:0]      count;
		logic [11:0]      first;
		logic [ORD_W-1:0] ord;
	} bpa_cmd_t;

	typedef enum logic [3:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_RG_PICK,
		BK_PB_RD,
		BK_PB_WR,
		BK_SR_RD,
		BK_SR_CHK,
		BK_SP_RD,
		BK_SP_WR,
		BK_A_FIN,
		BK_DONE
	} back_state_t;

endpackage

>>> hdl/bpa_front.sv
// ----------------------------------------------------------------------------
// bpa_front
// Accepts request transactions and classifies them: zero count, range past
// end, oversize count, and the rounded order of an allocation.
// ----------------------------------------------------------------------------
module bpa_front (
	input  logic              start,
	input  logic              q_full,
	input  bpa_pkg::bpa_req_t req,
	output logic              push,
	output bpa_pkg::bpa_cmd_t cmd
);
	import bpa_pkg::*;

	localparam int PB = PAGE_INDEX_BITS;
	localparam int SW = (PB + 2 > 14) ? PB + 2 : 14;

	logic [SW-1:0]    range_end;
	logic [SW-1:0]    space;
	logic [12:0]      cnt_m1;
	logic [ORD_W-1:0] ord;

	assign push = start && !q_full;

	// range end against the page space
	assign range_end = SW'(req.first_page) + SW'(req.page_count);
	assign space     = SW'(1) << PB;

	// rounded-up order of the count
	always_comb begin
		cnt_m1 = req.page_count - 13'd1;
		ord    = '0;
		for (int i = 0; i < 13; i++) begin
			if (cnt_m1[i])
				ord = ORD_W'(i + 1);
		end
	end

	// classify
	always_comb begin
		cmd.kind       = CMD_ALLOC;
		cmd.rej_status = STAT_OK;
		cmd.big        = SW'(req.page_count) > space;
		cmd.count      = req.page_count;
		cmd.first      = req.first_page;
		cmd.ord        = (req.page_count == 13'd1) ? '0 : ord;
		if (req.page_count == 13'd0) begin
			cmd.kind       = CMD_REJECT;
			cmd.rej_status = STAT_ZERO;
		end else if (req.opcode == OP_FREE) begin
			if (range_end > space) begin
				cmd.kind       = CMD_REJECT;
				cmd.rej_status = STAT_PAST_END;
			end else begin
				cmd.kind = CMD_FREE;
			end
		end
	end

endmodule

>>> hdl/bpa_queue.sv
// ----------------------------------------------------------------------------
// bpa_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module bpa_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bpa_pkg::bpa_cmd_t push_cmd,
	input  logic              pop,
	output bpa_pkg::bpa_cmd_t head,
	output logic              empty,
	output logic              full
);
	import bpa_pkg::*;

	bpa_cmd_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign empty = (fill_q == 2'd0);
	assign full  = (fill_q == 2'd2);
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

>>> hdl/bpa_back.sv
// ----------------------------------------------------------------------------
// bpa_back
// Executes classified commands on the free-block mark memory: block search,
// split, range release with buddy merge, and free page bookkeeping.
// ----------------------------------------------------------------------------
module bpa_back #(
	parameter int ORDER_COUNT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  bpa_pkg::bpa_cmd_t cmd,
	output logic              pop,
	output logic              done,
	output bpa_pkg::bpa_rsp_t rsp
);
	import bpa_pkg::*;

	localparam int PB   = PAGE_INDEX_BITS;
	localparam int TOP  = ((ORDER_COUNT < PB + 1) ? ORDER_COUNT : PB + 1) - 1;
	localparam int IB   = PB + 1;
	localparam int LW   = (IB - 1 < 6) ? IB - 1 : 6;
	localparam int W    = 1 << LW;
	localparam int RB   = IB - LW;
	localparam int ROWS = 1 << RB;
	localparam int CB   = PB + 1;
	localparam int OB   = $clog2(PB + 2);
	localparam logic [CB-1:0] SPACE = {1'b1, {PB{1'b0}}};

	// mark number of the block of order o at page pg
	function automatic logic [IB-1:0] mark_idx(input logic [OB-1:0] o,
		input logic [PB-1:0] pg);
		mark_idx = (IB'(1) << (PB - int'(o))) + (IB'(pg) >> o);
	endfunction

	// first and last memory rows holding the marks of order s
	function automatic logic [RB-1:0] row_first(input logic [OB-1:0] s);
		logic [IB-1:0] lo;
		lo        = IB'(1) << (PB - int'(s));
		row_first = lo[IB-1:LW];
	endfunction

	function automatic logic [RB-1:0] row_last(input logic [OB-1:0] s);
		logic [IB-1:0] hi_m1;
		hi_m1    = (IB'(1) << (PB - int'(s) + 1)) - IB'(1);
		row_last = hi_m1[IB-1:LW];
	endfunction

	back_state_t state_q, state_d;

	logic [W-1:0]  mem [ROWS];
	logic [W-1:0]  rdata_q;
	logic [RB-1:0] raddr, waddr;
	logic [W-1:0]  wdata;
	logic          we;

	logic [CB-1:0] ft_q;
	logic [RB-1:0] row_q;
	logic [2:0]    status_q;
	logic [11:0]   granted_q;
	logic [PB:0]   rg_page_q;
	logic [CB-1:0] rg_cnt_q;
	logic [PB-1:0] blk_page_q;
	logic [OB-1:0] blk_ord_q;
	logic [OB-1:0] s_q;
	logic [OB-1:0] a_ord_q;
	logic [CB-1:0] a_cnt_q;
	logic [PB-1:0] gpage_q;

	logic [OB-1:0] tz, lg, pick_o;
	logic [IB-1:0] blk_idx;
	logic [LW-1:0] own_pos, bud_pos;
	logic          merge;
	logic [IB-1:0] lo_s;
	logic [W-1:0]  msk, hit_v;
	logic          hit;
	logic [LW-1:0] hb;
	logic [IB-1:0] found_idx;
	logic [PB-1:0] page_f;
	logic          last_row;
	logic [IB-1:0] split_idx;
	logic [CB-1:0] cnt_c;
	logic [CB:0]   ft_sum;
	logic [CB-1:0] ft_sat;
	logic [OB-1:0] ord_c;
	logic          exceed, noblk;
	logic [CB-1:0] excess;

	// block size picked for the next piece of a range
	always_comb begin
		tz = OB'(TOP);
		for (int i = PB - 1; i >= 0; i--) begin
			if (rg_page_q[i] && i < TOP)
				tz = OB'(i);
		end
		lg = '0;
		for (int i = 0; i < CB; i++) begin
			if (rg_cnt_q[i])
				lg = OB'(i);
		end
		pick_o = (tz < lg) ? tz : lg;
	end

	// buddy check of the block being released
	assign blk_idx = mark_idx(blk_ord_q, blk_page_q);
	assign own_pos = blk_idx[LW-1:0];
	assign bud_pos = own_pos ^ LW'(1);
	assign merge   = (blk_ord_q < OB'(TOP)) && rdata_q[bud_pos];

	// search of one row for a free block of order s
	always_comb begin
		lo_s = IB'(1) << (PB - int'(s_q));
		for (int b = 0; b < W; b++)
			msk[b] = (lo_s >= IB'(W)) ||
				((IB'(b) >= lo_s) && (IB'(b) < (lo_s << 1)));
		hit_v = rdata_q & msk;
		hit   = |hit_v;
		hb    = '0;
		for (int b = W - 1; b >= 0; b--) begin
			if (hit_v[b])
				hb = LW'(b);
		end
		found_idx = {row_q, hb};
		page_f    = PB'((found_idx - lo_s) << s_q);
		last_row  = (row_q == row_last(s_q));
		split_idx = mark_idx(s_q, gpage_q + (PB'(1) << s_q));
	end

	// command checks and free total arithmetic
	assign cnt_c  = CB'(cmd.count);
	assign ft_sum = (CB + 1)'(ft_q) + (CB + 1)'(cnt_c);
	assign ft_sat = (ft_sum > (CB + 1)'(SPACE)) ? SPACE : ft_sum[CB-1:0];
	assign ord_c  = OB'(cmd.ord);
	assign exceed = cmd.big || (cnt_c > ft_q);
	assign noblk  = ord_c > OB'(TOP);
	assign excess = (CB'(1) << a_ord_q) - a_cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR:   if (row_q == RB'(ROWS - 1)) state_d = BK_IDLE;
			BK_IDLE: begin
				if (!q_empty) begin
					case (cmd.kind)
						CMD_FREE:  state_d = BK_RG_PICK;
						CMD_ALLOC: state_d = (exceed || noblk) ? BK_DONE : BK_SR_RD;
						default:   state_d = BK_DONE;
					endcase
				end
			end
			BK_RG_PICK: state_d = (rg_cnt_q == '0) ? BK_DONE : BK_PB_RD;
			BK_PB_RD:   state_d = BK_PB_WR;
			BK_PB_WR:   state_d = merge ? BK_PB_RD : BK_RG_PICK;
			BK_SR_RD:   state_d = BK_SR_CHK;
			BK_SR_CHK: begin
				if (hit)
					state_d = (s_q > a_ord_q) ? BK_SP_RD : BK_A_FIN;
				else if (last_row && s_q == OB'(TOP))
					state_d = BK_DONE;
				else
					state_d = BK_SR_RD;
			end
			BK_SP_RD:   state_d = BK_SP_WR;
			BK_SP_WR:   state_d = (s_q > a_ord_q) ? BK_SP_RD : BK_A_FIN;
			BK_A_FIN:   state_d = BK_RG_PICK;
			BK_DONE:    state_d = BK_IDLE;
			default:    state_d = BK_IDLE;
		endcase
	end

	// memory control and handshake outputs
	always_comb begin
		raddr = row_q;
		waddr = row_q;
		wdata = rdata_q;
		we    = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				we    = 1'b1;
				wdata = '0;
			end
			BK_PB_RD: raddr = blk_idx[IB-1:LW];
			BK_PB_WR: begin
				we    = 1'b1;
				waddr = blk_idx[IB-1:LW];
				if (merge)
					wdata[bud_pos] = 1'b0;
				else
					wdata[own_pos] = 1'b1;
			end
			BK_SR_CHK: begin
				we        = hit;
				wdata[hb] = 1'b0;
			end
			BK_SP_RD: raddr = split_idx[IB-1:LW];
			BK_SP_WR: begin
				we                       = 1'b1;
				waddr                    = split_idx[IB-1:LW];
				wdata[split_idx[LW-1:0]] = 1'b1;
			end
			default: ;
		endcase
	end

	assign pop  = (state_q == BK_IDLE) && !q_empty;
	assign done = (state_q == BK_DONE);
	assign rsp  = '{status: status_q, granted_page: granted_q, pages_free: 13'(ft_q)};

	// mark memory
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// control state, free total, row pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			ft_q    <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_CLEAR: row_q <= row_q + RB'(1);
				BK_IDLE: begin
					if (!q_empty && cmd.kind == CMD_FREE)
						ft_q <= ft_sat;
					if (!q_empty && cmd.kind == CMD_ALLOC)
						row_q <= row_first(ord_c);
				end
				BK_SR_CHK: begin
					if (!hit && last_row && s_q != OB'(TOP))
						row_q <= row_first(s_q + OB'(1));
					else if (!hit)
						row_q <= row_q + RB'(1);
				end
				BK_A_FIN: ft_q <= ft_q - a_cnt_q;
				default: ;
			endcase
		end
	end

	// working registers of the current command
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					granted_q <= '0;
					case (cmd.kind)
						CMD_FREE: begin
							status_q  <= STAT_OK;
							rg_page_q <= (PB + 1)'(PB'(cmd.first));
							rg_cnt_q  <= cnt_c;
						end
						CMD_ALLOC: begin
							if (exceed)
								status_q <= STAT_EXCEEDS;
							else if (noblk)
								status_q <= STAT_NO_BLOCK;
							else
								status_q <= STAT_OK;
							s_q     <= ord_c;
							a_ord_q <= ord_c;
							a_cnt_q <= cnt_c;
						end
						default: status_q <= cmd.rej_status;
					endcase
				end
			end
			BK_RG_PICK: begin
				blk_page_q <= rg_page_q[PB-1:0];
				blk_ord_q  <= pick_o;
				rg_page_q  <= rg_page_q + ((PB + 1)'(1) << pick_o);
				rg_cnt_q   <= rg_cnt_q - (CB'(1) << pick_o);
			end
			BK_PB_WR: begin
				if (merge) begin
					blk_page_q <= blk_page_q & ~(PB'(1) << blk_ord_q);
					blk_ord_q  <= blk_ord_q + OB'(1);
				end
			end
			BK_SR_CHK: begin
				if (hit) begin
					gpage_q   <= page_f;
					granted_q <= 12'(page_f);
					if (s_q > a_ord_q)
						s_q <= s_q - OB'(1);
				end else if (last_row) begin
					if (s_q == OB'(TOP))
						status_q <= STAT_NO_BLOCK;
					else
						s_q <= s_q + OB'(1);
				end
			end
			BK_SP_WR: begin
				if (s_q > a_ord_q)
					s_q <= s_q - OB'(1);
			end
			BK_A_FIN: begin
				rg_page_q <= (PB + 1)'(gpage_q) + (PB + 1)'(a_cnt_q);
				rg_cnt_q  <= excess;
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/buddy_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Buddy page allocator: allocate and free page runs over a fixed page space.
//
//   channel   ports                 direction  transfer
//   request   start, busy, req      in         start high while busy low
//   result    done, rsp             out        one cycle strobe, no stall
//
// After reset a clearing pass writes the mark memory, 2^(PAGE_INDEX_BITS+1)/64
// rows at one row a cycle (128 rows here); requests queue meanwhile.
// Each block search row, merge or split step reads the mark memory and then
// checks or writes it; the mark memory sets the pace.
// busy rises when the two-entry command queue is full.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit #(
	parameter int ORDER_COUNT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bpa_pkg::bpa_req_t req,
	output logic              done,
	output bpa_pkg::bpa_rsp_t rsp
);
	import bpa_pkg::*;

	logic     push, pop, q_empty, q_full;
	bpa_cmd_t push_cmd, head;

	assign busy = q_full;

	// classification
	bpa_front u_front (
		.start  (start),
		.q_full (q_full),
		.req    (req),
		.push   (push),
		.cmd    (push_cmd)
	);

	// command queue
	bpa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// execution
	bpa_back #(
		.ORDER_COUNT (ORDER_COUNT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.cmd     (head),
		.pop     (pop),
		.done    (done),
		.rsp     (rsp)
	);

endmodule

>>> hdl/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the buddy page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input bpa_pkg::bpa_req_t req,
	input logic              done,
	input bpa_pkg::bpa_rsp_t rsp
);
	import bpa_pkg::*;

	logic [1:0] outst_q;
	logic       accept;

	assign accept = start && !busy;

	// transactions accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outst_q <= 2'd0;
		else if (accept && !done)
			outst_q <= outst_q + 2'd1;
		else if (done && !accept)
			outst_q <= outst_q - 2'd1;
	end

	// no result without a pending transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> outst_q != 2'd0)
		else $error("result without pending transaction");

	// queue plus engine hold three at most
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q == 2'd3 |-> busy)
		else $error("accepting beyond capacity");

	// results never come back to back
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back to back results");

	// failed requests grant nothing
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != STAT_OK |-> rsp.granted_page == 12'd0)
		else $error("grant on failed request");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (.*);
